// File: sv/extended_gcd_modular_inverse_assert.svh
// assertion macros for the extended gcd / modular inverse block
// no dependencies; included by the checker file
`ifndef EXTENDED_GCD_MODULAR_INVERSE_ASSERT_SVH
`define EXTENDED_GCD_MODULAR_INVERSE_ASSERT_SVH

// same-cycle implication, held off during reset
`define EGCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("egcd assertion failed");

// next-cycle implication, held off during reset
`define EGCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("egcd assertion failed");

`endif

// File: sv/egcd_pkg.sv
// shared types for the extended gcd / modular inverse block
// no dependencies; used by the interfaces, controller, datapath and checker
package egcd_pkg;

    localparam int MOD_W = 31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_REDUCE,
        ST_CHECK,
        ST_ROUND,
        ST_INVERT,
        ST_EMIT
    } egcd_state_t;

    typedef enum logic [1:0] {
        DIV_ROUND,
        DIV_REDUCE,
        DIV_INVERT
    } egcd_div_sel_t;

    typedef struct packed {
        logic          load;
        logic          div_start;
        egcd_div_sel_t div_sel;
        logic          red_apply;
        logic          round_apply;
        logic          inv_apply;
        logic          emit;
    } egcd_cmd_t;

    typedef struct packed {
        logic need_reduce;
        logic r_new_zero;
        logic gcd_one;
        logic div_done;
        logic out_free;
    } egcd_stat_t;

endpackage

// File: sv/egcd_ifs.sv
// valid/ready channel interfaces for request and result items
// depends on egcd_pkg
interface egcd_req_if import egcd_pkg::*; #(parameter int WIDTH = 32) ();
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] operand_value;
    logic [MOD_W-1:0]        modulus;

    modport source (output valid, output operand_value, output modulus, input ready);
    modport sink   (input valid, input operand_value, input modulus, output ready);
endinterface

interface egcd_rsp_if import egcd_pkg::*; #(parameter int WIDTH = 32) ();
    logic                    valid;
    logic                    ready;
    logic [MOD_W-1:0]        gcd_value;
    logic signed [WIDTH-1:0] coef_s;
    logic signed [WIDTH-1:0] coef_t;
    logic [MOD_W-1:0]        inverse;
    logic                    has_inverse;

    modport source (output valid, output gcd_value, output coef_s, output coef_t,
                    output inverse, output has_inverse, input ready);
    modport sink   (input valid, input gcd_value, input coef_s, input coef_t,
                    input inverse, input has_inverse, output ready);
endinterface

// File: sv/egcd_div.sv
// radix-2 restoring divider, one quotient bit per cycle, msb first
// quotient bits also drive two shift-add accumulators giving q*mul_a and q*mul_b
module egcd_div #(
    parameter int RW = 31,
    parameter int DW = 32,
    parameter int CW = 33
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [RW-1:0] divisor,
    input  logic [CW-1:0] mul_a,
    input  logic [CW-1:0] mul_b,
    output logic          done,
    output logic [RW-1:0] rem,
    output logic [CW-1:0] prod_a,
    output logic [CW-1:0] prod_b
);
    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    dvd_reg;
    logic [RW-1:0]    rem_reg, dsr_reg;
    logic [CW-1:0]    mul_a_reg, mul_b_reg, acc_a_reg, acc_b_reg;

    logic [RW:0]      shifted, diff;
    logic             qbit;
    logic [RW-1:0]    rem_step;
    logic [CW-1:0]    acc_a_step, acc_b_step;

    always_comb
    begin
        shifted    = {rem_reg, dvd_reg[DW-1]};
        diff       = shifted - {1'b0, dsr_reg};
        qbit       = (shifted >= {1'b0, dsr_reg});
        rem_step   = qbit ? diff[RW-1:0] : shifted[RW-1:0];
        acc_a_step = {acc_a_reg[CW-2:0], 1'b0} + (qbit ? mul_a_reg : '0);
        acc_b_step = {acc_b_reg[CW-2:0], 1'b0} + (qbit ? mul_b_reg : '0);
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DW);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg   <= dividend;
            dsr_reg   <= divisor;
            rem_reg   <= '0;
            mul_a_reg <= mul_a;
            mul_b_reg <= mul_b;
            acc_a_reg <= '0;
            acc_b_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg   <= {dvd_reg[DW-2:0], 1'b0};
            rem_reg   <= rem_step;
            acc_a_reg <= acc_a_step;
            acc_b_reg <= acc_b_step;
        end
    end

    assign done   = done_reg;
    assign rem    = rem_reg;
    assign prod_a = acc_a_reg;
    assign prod_b = acc_b_reg;
endmodule

// File: sv/egcd_ctrl.sv
// sequencing state machine for the extended gcd block
// depends on egcd_pkg; drives egcd_dpath through egcd_cmd_t
module egcd_ctrl import egcd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  egcd_stat_t stat,
    output egcd_cmd_t  cmd
);
    egcd_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req_valid)
                    state_next = ST_PREP;
            ST_PREP:
                state_next = stat.need_reduce ? ST_REDUCE : ST_CHECK;
            ST_REDUCE:
                if (stat.div_done)
                    state_next = ST_CHECK;
            ST_CHECK:
                priority if (!stat.r_new_zero)
                    state_next = ST_ROUND;
                else if (stat.gcd_one)
                    state_next = ST_INVERT;
                else
                    state_next = ST_EMIT;
            ST_ROUND:
                if (stat.div_done)
                    state_next = ST_CHECK;
            ST_INVERT:
                if (stat.div_done)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (stat.out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready       = 1'b0;
        cmd             = '0;
        cmd.div_sel     = DIV_ROUND;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            ST_PREP:
            begin
                cmd.div_start = stat.need_reduce;
                cmd.div_sel   = DIV_REDUCE;
            end
            ST_REDUCE:
                cmd.red_apply = stat.div_done;
            ST_CHECK:
            begin
                cmd.div_start = !stat.r_new_zero || stat.gcd_one;
                cmd.div_sel   = stat.r_new_zero ? DIV_INVERT : DIV_ROUND;
            end
            ST_ROUND:
                cmd.round_apply = stat.div_done;
            ST_INVERT:
                cmd.inv_apply = stat.div_done;
            ST_EMIT:
                cmd.emit = stat.out_free;
            default:
                req_ready = 1'b0;
        endcase
    end
endmodule

// File: sv/egcd_dpath.sv
// remainder and coefficient registers, operand muxing and result register
// depends on egcd_pkg and egcd_div; commanded by egcd_ctrl
module egcd_dpath import egcd_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  egcd_cmd_t               cmd,
    output egcd_stat_t              stat,
    input  logic signed [WIDTH-1:0] operand_value,
    input  logic [MOD_W-1:0]        modulus,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic [MOD_W-1:0]        gcd_value,
    output logic signed [WIDTH-1:0] coef_s,
    output logic signed [WIDTH-1:0] coef_t,
    output logic [MOD_W-1:0]        inverse,
    output logic                    has_inverse
);
    // remainders fit the wider of a non-negative operand and the modulus
    localparam int RW = (WIDTH - 1 > MOD_W) ? WIDTH - 1 : MOD_W;
    localparam int DW = RW + 1;
    localparam int CW = RW + 2;

    logic [WIDTH-1:0] opnd_reg;
    logic             neg_reg;
    logic [RW-1:0]    m_reg, r_old_reg, r_new_reg, inv_reg;
    logic [CW-1:0]    s_old_reg, s_new_reg, t_old_reg, t_new_reg;
    logic             out_valid_reg, out_valid_next;

    logic             in_zero, in_neg;
    logic [WIDTH-1:0] mag;
    logic [CW-1:0]    s_mag;
    logic [DW-1:0]    div_dividend;
    logic [RW-1:0]    div_divisor;
    logic             div_done;
    logic [RW-1:0]    div_rem;
    logic [CW-1:0]    prod_s, prod_t;
    logic [RW-1:0]    rem_wrapped;

    assign in_zero     = (modulus == '0);
    assign in_neg      = operand_value[WIDTH-1];
    assign mag         = -opnd_reg;
    assign s_mag       = s_old_reg[CW-1] ? -s_old_reg : s_old_reg;
    assign rem_wrapped = (div_rem == '0) ? '0 : m_reg - div_rem;

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_REDUCE:
            begin
                div_dividend = DW'(mag);
                div_divisor  = m_reg;
            end
            DIV_INVERT:
            begin
                div_dividend = s_mag[DW-1:0];
                div_divisor  = m_reg;
            end
            default:
            begin
                div_dividend = DW'(r_old_reg);
                div_divisor  = r_new_reg;
            end
        endcase
    end

    egcd_div #(
        .RW(RW),
        .DW(DW),
        .CW(CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .mul_a    (s_new_reg),
        .mul_b    (t_new_reg),
        .done     (div_done),
        .rem      (div_rem),
        .prod_a   (prod_s),
        .prod_b   (prod_t)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            opnd_reg  <= operand_value;
            neg_reg   <= in_neg;
            m_reg     <= RW'(modulus);
            r_old_reg <= (in_zero || in_neg) ? '0 : RW'(operand_value[WIDTH-2:0]);
            r_new_reg <= RW'(modulus);
            s_old_reg <= in_zero ? '0 : CW'(1);
            s_new_reg <= '0;
            t_old_reg <= '0;
            t_new_reg <= CW'(1);
            inv_reg   <= '0;
        end
        else if (cmd.red_apply)
        begin
            r_old_reg <= rem_wrapped;
        end
        else if (cmd.round_apply)
        begin
            r_old_reg <= r_new_reg;
            r_new_reg <= div_rem;
            s_old_reg <= s_new_reg;
            s_new_reg <= s_old_reg - prod_s;
            t_old_reg <= t_new_reg;
            t_new_reg <= t_old_reg - prod_t;
        end
        else if (cmd.inv_apply)
        begin
            inv_reg <= s_old_reg[CW-1] ? rem_wrapped : div_rem;
        end
    end

    // result register, free when empty or being drained this cycle
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            gcd_value   <= r_old_reg[MOD_W-1:0];
            coef_s      <= s_old_reg[WIDTH-1:0];
            coef_t      <= t_old_reg[WIDTH-1:0];
            inverse     <= inv_reg[MOD_W-1:0];
            has_inverse <= (r_old_reg == RW'(1));
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign stat.need_reduce = neg_reg && (m_reg != '0);
    assign stat.r_new_zero  = (r_new_reg == '0);
    assign stat.gcd_one     = (r_old_reg == RW'(1));
    assign stat.div_done    = div_done;
    assign stat.out_free    = !out_valid_reg || rsp_ready;
endmodule

// File: sv/extended_gcd_modular_inverse.sv
// top level of the extended gcd / modular inverse block
// depends on egcd_pkg, egcd_ifs, egcd_ctrl, egcd_dpath (and egcd_div below it)
//
// channel | dir | payload
// --------+-----+--------------------------------------------------------
// req     | in  | operand_value (WIDTH, signed), modulus (31)
// rsp     | out | gcd_value (31), coef_s, coef_t (WIDTH, signed),
//         |     | inverse (31), has_inverse (1)
//
// one item is in work at a time; the shared divider makes one quotient bit per
// cycle over DW = max(WIDTH, 32) bits in each Euclid round
// a negative operand with a nonzero modulus adds a reduction divide, and a gcd
// of one adds an inverse divide
// reset clears the controller, the divider's counter and busy/done flags, and the result valid flag only
// a waiting result does not block the next item until that item's own result is due
module extended_gcd_modular_inverse import egcd_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    egcd_req_if.sink   req,
    egcd_rsp_if.source rsp
);
    egcd_cmd_t  cmd;
    egcd_stat_t stat;

    // sequencing: idle, optional reduction, rounds, optional inverse fixup, emit
    egcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // remainders, Bezout coefficients, shared divider and result register
    egcd_dpath #(
        .WIDTH(WIDTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operand_value (req.operand_value),
        .modulus       (req.modulus),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .gcd_value     (rsp.gcd_value),
        .coef_s        (rsp.coef_s),
        .coef_t        (rsp.coef_t),
        .inverse       (rsp.inverse),
        .has_inverse   (rsp.has_inverse)
    );
endmodule

// File: sv/egcd_checker.sv
// port-level checks on the extended gcd block, bound to the top level
// depends on egcd_pkg and extended_gcd_modular_inverse_assert.svh
`include "extended_gcd_modular_inverse_assert.svh"

module egcd_checker import egcd_pkg::*; #(
    parameter int WIDTH = 32
) (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [MOD_W-1:0] gcd_value,
    input logic [WIDTH-1:0] coef_s,
    input logic [MOD_W-1:0] inverse,
    input logic             has_inverse
);
    // a stalled item stays offered
    `EGCD_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    // one item at a time: no accept in the cycle after an accept
    `EGCD_ASSERT_NXT(a_one_item, clk, rst_n, req_valid && req_ready, !req_ready)
    // the flag only with a unit gcd
    `EGCD_ASSERT_IMP(a_flag_gcd, clk, rst_n, rsp_valid && has_inverse, gcd_value == MOD_W'(1))
    // no inverse reported without the flag
    `EGCD_ASSERT_IMP(a_inv_zero, clk, rst_n, rsp_valid && !has_inverse, inverse == '0)
    // zero gcd comes only with a zero coefficient
    `EGCD_ASSERT_IMP(a_gcd_zero, clk, rst_n, rsp_valid && gcd_value == '0, coef_s == '0)
endmodule

bind extended_gcd_modular_inverse egcd_checker #(
    .WIDTH(WIDTH)
) u_egcd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .gcd_value   (rsp.gcd_value),
    .coef_s      (rsp.coef_s),
    .inverse     (rsp.inverse),
    .has_inverse (rsp.has_inverse)
);
